>>> rtl/core/gvc_pkg.sv
// ----------------------------------------------------------------------------
// gvc_pkg
// Shared types and constants of the greedy vertex coloring core.
// ----------------------------------------------------------------------------
package gvc_pkg;

    // Fixed field widths.
    localparam int VTX_W      = 6;   // vertex number on the ports
    localparam int COLOR_W    = 3;   // color code, 0 means uncolored
    localparam int CNT_W      = 7;   // vertex_count register
    localparam int LIMIT_W    = 3;   // color_limit register
    localparam int S_TDATA_W  = 16;  // source_vertex, target_vertex, zero fill
    localparam int M_TDATA_W  = 16;  // vertex, color, zero fill

    // Palette size that the hardware tracks; larger limits are clamped to it.
    localparam int NUM_COLORS = 6;

    // Depth of the command queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;

    // Default size of the graph storage.
    localparam int MAX_VERTICES_DEF = 64;

    // Reset values of the configuration registers.
    localparam logic [CNT_W-1:0]   VERTEX_COUNT_RST = 7'd64;
    localparam logic [LIMIT_W-1:0] COLOR_LIMIT_RST  = 3'd6;

    // Configuration register indexes.
    localparam logic CFG_VERTEX_COUNT = 1'b0;
    localparam logic CFG_COLOR_LIMIT  = 1'b1;

    // Operation codes carried in s_tuser.
    localparam logic OP_ADD_EDGE = 1'b0;
    localparam logic OP_COLOR    = 1'b1;

    // One queued command: an edge to add or a color run.
    typedef struct packed {
        logic             is_color;
        logic [VTX_W-1:0] src;
        logic [VTX_W-1:0] dst;
    } gvc_cmd_t;

    // Back end sequencer states.
    typedef enum logic {
        GVC_RUN,
        GVC_COLOR
    } gvc_state_t;

endpackage

>>> rtl/core/gvc_ram.sv
// ----------------------------------------------------------------------------
// gvc_ram
// Generic single-write, single-read RAM with a registered, read-first output.
// ----------------------------------------------------------------------------
module gvc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/gvc_front.sv
// ----------------------------------------------------------------------------
// gvc_front
// Input side: accepts commands, drops edges outside the graph, feeds the queue.
// ----------------------------------------------------------------------------
module gvc_front (
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [gvc_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                        s_tuser,
    input  logic [gvc_pkg::CNT_W-1:0]   vertex_count_eff,
    input  logic                        queue_full,
    output logic                        push_valid,
    output gvc_pkg::gvc_cmd_t           push_cmd
);

    logic [gvc_pkg::VTX_W-1:0] src;
    logic [gvc_pkg::VTX_W-1:0] dst;
    logic                      edge_ok;

    assign src = s_tdata[gvc_pkg::VTX_W-1:0];
    assign dst = s_tdata[2*gvc_pkg::VTX_W-1:gvc_pkg::VTX_W];

    // An edge is kept only if both ends are real vertices of the current graph.
    assign edge_ok = (src != '0) && ({1'b0, src} < vertex_count_eff)
                  && (dst != '0) && ({1'b0, dst} < vertex_count_eff);

    assign s_tready = !queue_full;

    assign push_valid = s_tvalid && s_tready && ((s_tuser == gvc_pkg::OP_COLOR) || edge_ok);

    always_comb begin
        push_cmd.is_color = (s_tuser == gvc_pkg::OP_COLOR);
        push_cmd.src      = src;
        push_cmd.dst      = dst;
    end

endmodule

>>> rtl/core/gvc_queue.sv
// ----------------------------------------------------------------------------
// gvc_queue
// Short command FIFO between the front and the back.
// ----------------------------------------------------------------------------
module gvc_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push_valid,
    input  gvc_pkg::gvc_cmd_t push_cmd,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output gvc_pkg::gvc_cmd_t head_cmd
);

    localparam int PTR_W = $clog2(gvc_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(gvc_pkg::QUEUE_DEPTH + 1);

    gvc_pkg::gvc_cmd_t entry_reg [gvc_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic              do_pop;

    assign full       = (fill_reg == CNT_W'(gvc_pkg::QUEUE_DEPTH));
    assign head_valid = (fill_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push_valid) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(gvc_pkg::QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(gvc_pkg::QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + PTR_W'(1);
        end
        if (push_valid && !do_pop) begin
            fill_next = fill_reg + CNT_W'(1);
        end else if (!push_valid && do_pop) begin
            fill_next = fill_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_valid) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> rtl/core/gvc_back.sv
// ----------------------------------------------------------------------------
// gvc_back
// Execution side: adjacency updates, the coloring sweep and the result register.
// ----------------------------------------------------------------------------
module gvc_back #(
    parameter int MAX_VERTICES = gvc_pkg::MAX_VERTICES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [gvc_pkg::CNT_W-1:0]     vertex_count_eff,
    input  logic [gvc_pkg::LIMIT_W-1:0]   color_limit_eff,
    input  logic                          head_valid,
    input  gvc_pkg::gvc_cmd_t             head_cmd,
    output logic                          pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [gvc_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tlast
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int NC = gvc_pkg::NUM_COLORS;

    gvc_pkg::gvc_state_t state_reg, state_next;

    // RAM port signals.
    logic                    rd_en;
    logic [AW-1:0]           rd_addr;
    logic [MAX_VERTICES-1:0] rd_data;
    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    logic [MAX_VERTICES-1:0] wr_data;

    // Edge write stage (second half of the read-modify-write).
    logic          s2_valid_reg;
    logic [AW-1:0] s2_row_reg;
    logic [AW-1:0] s2_col_reg;
    logic          s2_load;

    // Last written row, forwarded to a read that raced with it.
    logic                    fwd_valid_reg;
    logic [AW-1:0]           fwd_row_reg;
    logic [MAX_VERTICES-1:0] fwd_data_reg;

    logic [MAX_VERTICES-1:0]           row_valid_reg;
    logic [NC-1:0][MAX_VERTICES-1:0]   color_mask_reg;

    logic [gvc_pkg::VTX_W-1:0] col_vtx_reg, col_vtx_next;

    logic [gvc_pkg::VTX_W-1:0]   out_vtx_reg;
    logic [gvc_pkg::COLOR_W-1:0] out_color_reg;
    logic                        out_last_reg;
    logic                        out_valid_reg;

    // Sequencer outputs.
    logic out_free;
    logic start_color;
    logic emit;
    logic clear_all;

    logic                      tiny_graph;
    logic                      is_last_vtx;
    logic [MAX_VERTICES-1:0]   edge_base;
    logic [MAX_VERTICES-1:0]   color_row;
    logic [NC-1:0]             used;
    logic [gvc_pkg::COLOR_W-1:0] pick_color;
    logic                      pick_overflow;

    gvc_ram #(
        .WIDTH (MAX_VERTICES),
        .DEPTH (MAX_VERTICES)
    ) u_adj_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign out_free    = !out_valid_reg || m_tready;
    assign tiny_graph  = (vertex_count_eff < gvc_pkg::CNT_W'(2));
    assign is_last_vtx = ({1'b0, col_vtx_reg} == (vertex_count_eff - gvc_pkg::CNT_W'(1)));

    // Edge merge: newest data for the row, then set the target bit.
    always_comb begin
        if (fwd_valid_reg && (fwd_row_reg == s2_row_reg)) begin
            edge_base = fwd_data_reg;
        end else if (row_valid_reg[s2_row_reg]) begin
            edge_base = rd_data;
        end else begin
            edge_base = '0;
        end
        wr_en   = s2_valid_reg;
        wr_addr = s2_row_reg;
        wr_data = edge_base | (MAX_VERTICES'(1) << s2_col_reg);
    end

    // Neighbor row of the vertex being colored; an unwritten row counts as empty.
    assign color_row = row_valid_reg[col_vtx_reg[AW-1:0]] ? rd_data : '0;

    always_comb begin
        for (int i = 0; i < NC; i++) begin
            used[i] = |(color_row & color_mask_reg[i]);
        end
        pick_color = color_limit_eff + gvc_pkg::COLOR_W'(1);
        for (int i = NC - 1; i >= 0; i--) begin
            if ((gvc_pkg::COLOR_W'(i) < color_limit_eff) && !used[i]) begin
                pick_color = gvc_pkg::COLOR_W'(i + 1);
            end
        end
        pick_overflow = (pick_color > color_limit_eff);
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            gvc_pkg::GVC_RUN: begin
                if (start_color) begin
                    state_next = gvc_pkg::GVC_COLOR;
                end
            end
            gvc_pkg::GVC_COLOR: begin
                if (emit && is_last_vtx) begin
                    state_next = gvc_pkg::GVC_RUN;
                end
            end
            default: state_next = gvc_pkg::GVC_RUN;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        rd_en        = 1'b0;
        rd_addr      = '0;
        pop          = 1'b0;
        s2_load      = 1'b0;
        start_color  = 1'b0;
        emit         = 1'b0;
        clear_all    = 1'b0;
        col_vtx_next = col_vtx_reg;
        case (state_reg)
            gvc_pkg::GVC_RUN: begin
                if (head_valid && !head_cmd.is_color) begin
                    rd_en   = 1'b1;
                    rd_addr = head_cmd.src[AW-1:0];
                    pop     = 1'b1;
                    s2_load = 1'b1;
                end else if (head_valid && !s2_valid_reg) begin
                    if (tiny_graph) begin
                        pop       = 1'b1;
                        clear_all = 1'b1;
                    end else begin
                        rd_en        = 1'b1;
                        rd_addr      = AW'(1);
                        start_color  = 1'b1;
                        col_vtx_next = gvc_pkg::VTX_W'(1);
                    end
                end
            end
            gvc_pkg::GVC_COLOR: begin
                if (out_free) begin
                    emit = 1'b1;
                    if (is_last_vtx) begin
                        pop       = 1'b1;
                        clear_all = 1'b1;
                    end else begin
                        col_vtx_next = col_vtx_reg + gvc_pkg::VTX_W'(1);
                        rd_en        = 1'b1;
                        rd_addr      = col_vtx_next[AW-1:0];
                    end
                end
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= gvc_pkg::GVC_RUN;
            s2_valid_reg   <= 1'b0;
            fwd_valid_reg  <= 1'b0;
            row_valid_reg  <= '0;
            color_mask_reg <= '0;
            out_valid_reg  <= 1'b0;
            col_vtx_reg    <= '0;
        end else begin
            state_reg     <= state_next;
            col_vtx_reg   <= col_vtx_next;
            s2_valid_reg  <= s2_load;
            fwd_valid_reg <= s2_valid_reg && !clear_all;
            if (clear_all) begin
                row_valid_reg  <= '0;
                color_mask_reg <= '0;
            end else begin
                if (s2_valid_reg) begin
                    row_valid_reg[s2_row_reg] <= 1'b1;
                end
                if (emit && !pick_overflow) begin
                    color_mask_reg[pick_color - gvc_pkg::COLOR_W'(1)][col_vtx_reg[AW-1:0]]
                        <= 1'b1;
                end
            end
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s2_load) begin
            s2_row_reg <= head_cmd.src[AW-1:0];
            s2_col_reg <= head_cmd.dst[AW-1:0];
        end
        if (s2_valid_reg) begin
            fwd_row_reg  <= s2_row_reg;
            fwd_data_reg <= wr_data;
        end
        if (emit) begin
            out_vtx_reg   <= col_vtx_reg;
            out_color_reg <= pick_color;
            out_last_reg  <= is_last_vtx;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(gvc_pkg::M_TDATA_W - gvc_pkg::VTX_W - gvc_pkg::COLOR_W){1'b0}},
                       out_color_reg, out_vtx_reg};

endmodule

>>> rtl/core/greedy_vertex_coloring_core.sv
// ----------------------------------------------------------------------------
// greedy_vertex_coloring_core
// Adjacency loader and greedy vertex colorer with stream ports.
// ----------------------------------------------------------------------------
// Edge transfers are taken one per cycle while the queue has room; an edge passes
// through the queue, a RAM read of its source row, the merge and the RAM write.
// A color command waits for the last pending edge write, then produces one
// result per cycle from vertex 1 upward while the result register is free;
// a graph of fewer than two vertices yields no results.
// Synchronous active-low reset clears the queue, the row valid bits and the
// color masks at once; no clearing pass runs, and the RAM contents need none.
module greedy_vertex_coloring_core #(
    parameter int MAX_VERTICES = gvc_pkg::MAX_VERTICES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    // Configuration write port. Index 0: vertex_count, index 1: color_limit.
    input  logic                          cfg_wr_en,
    input  logic                          cfg_addr,
    input  logic [gvc_pkg::CNT_W-1:0]     cfg_wdata,

    // Command stream.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [gvc_pkg::S_TDATA_W-1:0] s_tdata,   // [5:0] source_vertex, [11:6] target_vertex
    input  logic                          s_tuser,   // [0] operation

    // Result stream.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [gvc_pkg::M_TDATA_W-1:0] m_tdata,   // [5:0] vertex, [8:6] color
    output logic                          m_tlast
);

    logic [gvc_pkg::CNT_W-1:0]   vertex_count_reg;
    logic [gvc_pkg::LIMIT_W-1:0] color_limit_reg;
    logic [gvc_pkg::CNT_W-1:0]   vertex_count_eff;
    logic [gvc_pkg::LIMIT_W-1:0] color_limit_eff;

    logic              push_valid;
    gvc_pkg::gvc_cmd_t push_cmd;
    logic              queue_full;
    logic              pop;
    logic              head_valid;
    gvc_pkg::gvc_cmd_t head_cmd;

    // Configuration registers. Write them only while the core is idle; the block itself does not enforce this.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vertex_count_reg <= gvc_pkg::VERTEX_COUNT_RST;
            color_limit_reg  <= gvc_pkg::COLOR_LIMIT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                gvc_pkg::CFG_VERTEX_COUNT: vertex_count_reg <= cfg_wdata;
                gvc_pkg::CFG_COLOR_LIMIT:  color_limit_reg  <= cfg_wdata[gvc_pkg::LIMIT_W-1:0];
                default:                   vertex_count_reg <= vertex_count_reg;
            endcase
        end
    end

    // The vertex count is clamped to the storage size, and a palette of
    // seven is treated as six so that the overflow color still fits.
    assign vertex_count_eff =
        (vertex_count_reg > gvc_pkg::CNT_W'(MAX_VERTICES))
        ? gvc_pkg::CNT_W'(MAX_VERTICES) : vertex_count_reg;
    assign color_limit_eff =
        (color_limit_reg > gvc_pkg::LIMIT_W'(gvc_pkg::NUM_COLORS))
        ? gvc_pkg::LIMIT_W'(gvc_pkg::NUM_COLORS) : color_limit_reg;

    // The front classifies each transfer; invalid edges are accepted and dropped.
    gvc_front u_front (
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .s_tuser          (s_tuser),
        .vertex_count_eff (vertex_count_eff),
        .queue_full       (queue_full),
        .push_valid       (push_valid),
        .push_cmd         (push_cmd)
    );

    // The queue lets new edges arrive while a coloring sweep is stalled.
    gvc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    // The back performs adjacency updates and the coloring sweep; its result
    // register decouples the sweep from the downstream ready.
    gvc_back #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .vertex_count_eff (vertex_count_eff),
        .color_limit_eff  (color_limit_eff),
        .head_valid       (head_valid),
        .head_cmd         (head_cmd),
        .pop              (pop),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .m_tlast          (m_tlast)
    );

    // The front never pushes into a full queue.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push_valid && queue_full))
        else $error("command pushed into a full queue");

    // A reported color never exceeds the overflow code of the palette.
    a_color_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[8:6] != '0)
                  && (m_tdata[8:6] <= color_limit_eff + gvc_pkg::LIMIT_W'(1)))
        else $error("reported color out of range");

    // Every reported vertex is a real vertex, and the marked one is the highest.
    a_vertex_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[5:0] != '0)
                  && ({1'b0, m_tdata[5:0]} < vertex_count_eff)
                  && (m_tlast == ({1'b0, m_tdata[5:0]}
                                  == vertex_count_eff - gvc_pkg::CNT_W'(1))))
        else $error("reported vertex out of range or wrongly marked");

endmodule
